### rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// shared types and constants of the box frustum cull unit
// ----------------------------------------------------------------------------
package bfc_pkg;

   localparam int MAX_PLANES = 6;
   localparam int PLANE_W    = 64;

   // register indexes on the configuration port
   localparam logic [2:0] REG_NUM_PLANES = 3'd0;
   localparam logic [2:0] REG_PLANE_0    = 3'd1;

   typedef enum logic [1:0] {
      VERDICT_INSIDE     = 2'd0,
      VERDICT_INTERSECTS = 2'd1,
      VERDICT_OUTSIDE    = 2'd2
   } verdict_type;

   typedef logic [MAX_PLANES-1:0][PLANE_W-1:0] plane_array_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic signed [15:0] center_z;
      logic [14:0]        extent_x;
      logic [14:0]        extent_y;
      logic [14:0]        extent_z;
      logic [5:0]         plane_mask;
      logic [2:0]         hint_plane;
   } item_type;

   // running result handed from cell to cell
   typedef struct packed {
      logic [5:0] straddle;
      logic       found;
      logic [2:0] reject_idx;
      logic       hint_rej;
      logic       hint_str;
   } acc_type;

endpackage

### rtl/bfc_csr.sv
// ----------------------------------------------------------------------------
// bfc_csr
// plane count and plane registers behind the configuration port
// ----------------------------------------------------------------------------
module bfc_csr
   import bfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [5:0]      paddr,
   input  logic [63:0]     pwdata,
   output logic [63:0]     prdata,
   output logic            pready,
   output logic [2:0]      active_count,
   output plane_array_type planes
);

   logic [2:0]      num_planes_ff;
   plane_array_type planes_ff;
   logic [2:0]      reg_idx;
   logic            wr_en;

   assign reg_idx = paddr[5:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_planes_ff <= 3'd6;
         planes_ff     <= '0;
      end else if (wr_en) begin
         if (reg_idx == REG_NUM_PLANES) begin
            num_planes_ff <= pwdata[2:0];
         end else if (reg_idx < 3'(MAX_PLANES + 1)) begin
            planes_ff[reg_idx - REG_PLANE_0] <= pwdata;
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_NUM_PLANES) begin
         prdata = {61'd0, num_planes_ff};
      end else if (reg_idx < 3'(MAX_PLANES + 1)) begin
         prdata = planes_ff[reg_idx - REG_PLANE_0];
      end
   end

   // counts above the plane limit clip to it
   assign active_count = (num_planes_ff > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : num_planes_ff;
   assign planes       = planes_ff;

endmodule

### rtl/bfc_cell.sv
// ----------------------------------------------------------------------------
// bfc_cell
// one plane test: product stage, then sum, classify and fold into the result
// ----------------------------------------------------------------------------
module bfc_cell
   import bfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   cell_idx,
   input  logic [2:0]   active_count,
   input  logic [63:0]  plane,
   input  logic         in_valid,
   output logic         in_ready,
   input  item_type     in_item,
   input  acc_type      in_acc,
   output logic         out_valid,
   input  logic         out_ready,
   output item_type     out_item,
   output acc_type      out_acc
);

   logic signed [15:0] n_x, n_y, n_z, plane_d;
   logic [15:0]        an_x, an_y, an_z;

   logic               a_v_ff, b_v_ff;
   item_type           a_item_ff, b_item_ff;
   acc_type            a_acc_ff, b_acc_ff;
   logic signed [31:0] pm_x_ff, pm_y_ff, pm_z_ff;
   logic signed [31:0] pm_x_in, pm_y_in, pm_z_in;
   logic [30:0]        pr_x_ff, pr_y_ff, pr_z_ff;
   logic [30:0]        pr_x_in, pr_y_in, pr_z_in;

   logic signed [35:0] m, r, hi, lo;
   logic               active, outside, straddles;
   logic [5:0]         plane_bit;
   acc_type            b_acc_in;
   logic               move_b;

   assign n_x     = plane[15:0];
   assign n_y     = plane[31:16];
   assign n_z     = plane[47:32];
   assign plane_d = plane[63:48];

   assign an_x = n_x[15] ? 16'(-n_x) : n_x;
   assign an_y = n_y[15] ? 16'(-n_y) : n_y;
   assign an_z = n_z[15] ? 16'(-n_z) : n_z;

   assign pm_x_in = n_x * in_item.center_x;
   assign pm_y_in = n_y * in_item.center_y;
   assign pm_z_in = n_z * in_item.center_z;
   assign pr_x_in = an_x * in_item.extent_x;
   assign pr_y_in = an_y * in_item.extent_y;
   assign pr_z_in = an_z * in_item.extent_z;

   assign move_b   = !b_v_ff || out_ready;
   assign in_ready = !a_v_ff || move_b;

   // distance term aligned to the products of the Q1.14 normals, which carry 14 fraction bits
   assign m  = 36'(pm_x_ff) + 36'(pm_y_ff) + 36'(pm_z_ff)
             + $signed({{6{plane_d[15]}}, plane_d, 14'd0});
   assign r  = $signed(36'(pr_x_ff) + 36'(pr_y_ff) + 36'(pr_z_ff));
   assign hi = m + r;
   assign lo = m - r;
   assign outside   = hi[35];
   assign straddles = lo[35];

   assign active    = a_item_ff.plane_mask[cell_idx] && (cell_idx < active_count);
   assign plane_bit = 6'b1 << cell_idx;

   always_comb begin
      b_acc_in = a_acc_ff;
      if (active) begin
         if (cell_idx == a_item_ff.hint_plane) begin
            b_acc_in.hint_rej = outside;
            b_acc_in.hint_str = !outside && straddles;
         end else if (!a_acc_ff.found) begin
            if (outside) begin
               b_acc_in.found      = 1'b1;
               b_acc_in.reject_idx = cell_idx;
            end else if (straddles) begin
               b_acc_in.straddle = a_acc_ff.straddle | plane_bit;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_v_ff <= in_valid;
         end
         if (move_b) begin
            b_v_ff <= a_v_ff;
         end
      end
      if (in_ready) begin
         a_item_ff <= in_item;
         a_acc_ff  <= in_acc;
         pm_x_ff   <= pm_x_in;
         pm_y_ff   <= pm_y_in;
         pm_z_ff   <= pm_z_in;
         pr_x_ff   <= pr_x_in;
         pr_y_ff   <= pr_y_in;
         pr_z_ff   <= pr_z_in;
      end
      if (move_b) begin
         b_item_ff <= a_item_ff;
         b_acc_ff  <= b_acc_in;
      end
   end

   assign out_valid = b_v_ff;
   assign out_item  = b_item_ff;
   assign out_acc   = b_acc_ff;

endmodule

### rtl/box_frustum_cull_coherent_unit.sv
// path: accepted req -> each plane cell's product and classify registers -> output register
// throughput: one word per cycle unless rsp_ready stalls, set by the six-cell chain where
//   each cell's multipliers and its compare each fill one register stage
// reset: synchronous, clears all valid flags, num_planes to 6, planes to 0
// ----------------------------------------------------------------------------
// box_frustum_cull_coherent_unit
// classifies a box against up to six frustum planes with a hint plane first
// ----------------------------------------------------------------------------
module box_frustum_cull_coherent_unit
   import bfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_center_x,
   input  logic signed [15:0] req_center_y,
   input  logic signed [15:0] req_center_z,
   input  logic [14:0]        req_extent_x,
   input  logic [14:0]        req_extent_y,
   input  logic [14:0]        req_extent_z,
   input  logic [5:0]         req_plane_mask,
   input  logic [2:0]         req_hint_plane,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_verdict,
   output logic [5:0]         rsp_straddle_mask,
   output logic [2:0]         rsp_next_hint,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [5:0]         paddr,
   input  logic [63:0]        pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   logic [2:0]      active_count;
   plane_array_type planes;

   logic     chain_valid [MAX_PLANES+1];
   logic     chain_ready [MAX_PLANES+1];
   item_type chain_item  [MAX_PLANES+1];
   acc_type  chain_acc   [MAX_PLANES+1];

   logic        rsp_valid_ff;
   verdict_type verdict_ff, verdict_in;
   logic [5:0]  straddle_ff, straddle_in;
   logic [2:0]  next_hint_ff, next_hint_in;
   logic [5:0]  hint_bit;
   logic        move_out;
   item_type    last_item;
   acc_type     last_acc;

   bfc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .active_count (active_count),
      .planes       (planes)
   );

   assign chain_valid[0]           = req_valid;
   assign req_ready                = chain_ready[0];
   assign chain_item[0].center_x   = req_center_x;
   assign chain_item[0].center_y   = req_center_y;
   assign chain_item[0].center_z   = req_center_z;
   assign chain_item[0].extent_x   = req_extent_x;
   assign chain_item[0].extent_y   = req_extent_y;
   assign chain_item[0].extent_z   = req_extent_z;
   assign chain_item[0].plane_mask = req_plane_mask;
   assign chain_item[0].hint_plane = req_hint_plane;
   assign chain_acc[0]             = '0;

   for (genvar g = 0; g < MAX_PLANES; g++) begin : g_cell
      bfc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_idx     (3'(g)),
         .active_count (active_count),
         .plane        (planes[g]),
         .in_valid     (chain_valid[g]),
         .in_ready     (chain_ready[g]),
         .in_item      (chain_item[g]),
         .in_acc       (chain_acc[g]),
         .out_valid    (chain_valid[g+1]),
         .out_ready    (chain_ready[g+1]),
         .out_item     (chain_item[g+1]),
         .out_acc      (chain_acc[g+1])
      );
   end

   assign move_out                = !rsp_valid_ff || rsp_ready;
   assign chain_ready[MAX_PLANES] = move_out;
   assign last_item               = chain_item[MAX_PLANES];
   assign last_acc                = chain_acc[MAX_PLANES];

   // hint straddle only ever set for a hint below the active count
   assign hint_bit = last_acc.hint_str ? (6'b1 << last_item.hint_plane) : 6'd0;

   always_comb begin
      next_hint_in = last_item.hint_plane;
      straddle_in  = last_acc.straddle | hint_bit;
      verdict_in   = (straddle_in != 6'd0) ? VERDICT_INTERSECTS : VERDICT_INSIDE;
      if (last_acc.hint_rej) begin
         verdict_in  = VERDICT_OUTSIDE;
         straddle_in = 6'd0;
      end else if (last_acc.found) begin
         verdict_in   = VERDICT_OUTSIDE;
         next_hint_in = last_acc.reject_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move_out) begin
         rsp_valid_ff <= chain_valid[MAX_PLANES];
      end
      if (move_out) begin
         verdict_ff   <= verdict_in;
         straddle_ff  <= straddle_in;
         next_hint_ff <= next_hint_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_straddle_mask = straddle_ff;
   assign rsp_next_hint     = next_hint_ff;

endmodule
